### rtl/core/dfp_pkg.sv
package dfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 6;

    // Operation codes carried on the opcode port.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    // Buffer select codes.
    localparam logic SEL_RX = 1'b0;
    localparam logic SEL_TX = 1'b1;

    // Request to one ring; at most one bit is set in any cycle.
    typedef struct packed {
        logic push;
        logic pop;
        logic peek;
        logic flush;
    } ring_req_t;

    // Occupancy status of one ring, valid in the cycle of the request.
    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage

### rtl/core/dfp_ram.sv
module dfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/dfp_ring.sv
module dfp_ring #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfp_pkg::ring_req_t           req,
    input  logic [dfp_pkg::BYTE_W-1:0]   push_byte,
    input  logic [dfp_pkg::OFFSET_W-1:0] peek_offset,
    output dfp_pkg::ring_stat_t          stat,
    output logic [dfp_pkg::BYTE_W-1:0]   rd_data
);

    import dfp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = (AW > OFFSET_W) ? AW : OFFSET_W;

    logic [AW-1:0]     rd_reg;
    logic [AW-1:0]     rd_next;
    logic [AW-1:0]     wr_reg;
    logic [AW-1:0]     wr_next;
    logic [AW-1:0]     wr_inc;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic              hit_reg;
    logic [SW-1:0]     peek_sum;
    logic [AW-1:0]     raddr;
    logic              push_do;
    logic              pop_do;
    logic              rd_en;
    logic [BYTE_W-1:0] ram_q;

    // The depth is a power of two, so wrapping is simply dropping the carry.
    assign wr_inc     = wr_reg + AW'(1);
    assign stat.full  = (wr_inc == rd_reg);
    assign stat.empty = (rd_reg == wr_reg);

    assign push_do = req.push && !stat.full;
    assign pop_do  = req.pop && !stat.empty;
    assign rd_en   = pop_do || req.peek;

    assign peek_sum = SW'(rd_reg) + SW'(peek_offset);
    assign raddr    = req.pop ? rd_reg : peek_sum[AW-1:0];

    always_comb
    begin
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        valid_next = valid_reg;
        if (req.flush)
        begin
            rd_next = '0;
            wr_next = '0;
        end
        else
        begin
            if (push_do)
            begin
                wr_next            = wr_inc;
                valid_next[wr_reg] = 1'b1;
            end
            if (pop_do)
            begin
                rd_next = rd_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            wr_reg    <= '0;
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            valid_reg <= valid_next;
            if (rd_en)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    dfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_do),
        .waddr (wr_reg),
        .wdata (push_byte),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // A slot never written since reset reads as zero.
    assign rd_data = hit_reg ? ram_q : '0;

endmodule

### rtl/core/dual_ring_fifo_with_peek.sv
// Channel   Direction  Transfer condition     Signals
// command   in         start && !busy         opcode, buffer_select, push_byte, peek_offset
// result    out        done (one cycle only)  ok, read_byte
//
// Each command gives exactly one result, with done high in the cycle after the transfer.
// A new command may be transferred in every cycle; the result delay is set by the
// registered read port of the storage memory that a pop or a peek reads.
// Reset clears the pointers and the per-slot written flags, so never-written slots read as
// zero at once; no clearing pass is needed and busy is never raised.
// The receiver cannot stall: a result is presented for exactly one cycle and then dropped.
module dual_ring_fifo_with_peek #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic                         buffer_select,
    input  logic [dfp_pkg::BYTE_W-1:0]   push_byte,
    input  logic [dfp_pkg::OFFSET_W-1:0] peek_offset,
    output logic                         done,
    output logic                         ok,
    output logic [dfp_pkg::BYTE_W-1:0]   read_byte
);

    import dfp_pkg::*;

    op_t         op;
    logic        accept;
    ring_req_t   rx_req;
    ring_req_t   tx_req;
    ring_stat_t  rx_stat;
    ring_stat_t  tx_stat;
    ring_stat_t  sel_stat;
    logic [BYTE_W-1:0] rx_data;
    logic [BYTE_W-1:0] tx_data;

    logic        done_reg;
    logic        ok_reg;
    logic        ok_next;
    logic        data_reg;
    logic        data_next;
    logic        sel_reg;

    // No command ever has to wait for an earlier one, so the block never holds off a
    // transfer. Back-to-back accesses to the same slot are safe because a write lands in
    // memory at the edge that ends its cycle, before any later read is issued.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign op     = op_t'(opcode);

    // Steer the command to the chosen ring. Flush always applies to the receive ring.
    always_comb
    begin
        rx_req       = '0;
        tx_req       = '0;
        rx_req.flush = accept && (op == OP_FLUSH);
        if (buffer_select == SEL_TX)
        begin
            tx_req.push = accept && (op == OP_PUSH);
            tx_req.pop  = accept && (op == OP_POP);
            tx_req.peek = accept && (op == OP_PEEK);
        end
        else
        begin
            rx_req.push = accept && (op == OP_PUSH);
            rx_req.pop  = accept && (op == OP_POP);
            rx_req.peek = accept && (op == OP_PEEK);
        end
    end

    assign sel_stat = (buffer_select == SEL_TX) ? tx_stat : rx_stat;

    // Success flag and whether the result carries a byte from memory.
    always_comb
    begin
        ok_next   = 1'b1;
        data_next = 1'b0;
        unique case (op)
            OP_PUSH:
            begin
                ok_next = !sel_stat.full;
            end
            OP_POP:
            begin
                ok_next   = !sel_stat.empty;
                data_next = !sel_stat.empty;
            end
            OP_PEEK:
            begin
                data_next = 1'b1;
            end
            OP_FLUSH:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            data_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                ok_reg   <= ok_next;
                data_reg <= data_next;
                sel_reg  <= buffer_select;
            end
        end
    end

    dfp_ring #(
        .DEPTH (DEPTH)
    ) u_rx (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (rx_req),
        .push_byte   (push_byte),
        .peek_offset (peek_offset),
        .stat        (rx_stat),
        .rd_data     (rx_data)
    );

    dfp_ring #(
        .DEPTH (DEPTH)
    ) u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (tx_req),
        .push_byte   (push_byte),
        .peek_offset (peek_offset),
        .stat        (tx_stat),
        .rd_data     (tx_data)
    );

    // The memory data arrives in the result cycle and is selected by the buffer latched
    // at the transfer; pushes, flushes and failed pops show zero.
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign read_byte = data_reg ? (sel_reg ? tx_data : rx_data) : '0;

endmodule

### rtl/core/dfp_checker.sv
module dfp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   opcode,
    input logic                         done,
    input logic                         ok,
    input logic [dfp_pkg::BYTE_W-1:0]   read_byte
);

    import dfp_pkg::*;

    logic accept;

    assign accept = start && !busy;

    // Every transfer gives a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result after a command transfer");

    // No result appears without a command before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a command");

    // A push never returns a byte.
    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_PUSH) |=> (read_byte == '0))
        else $error("push returned a non-zero byte");

    // Flush always succeeds and returns zero.
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_FLUSH) |=> ok && (read_byte == '0))
        else $error("flush result wrong");

    // Peek always succeeds.
    a_peek_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_PEEK) |=> ok)
        else $error("peek reported failure");

endmodule

bind dual_ring_fifo_with_peek dfp_checker u_dfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .done      (done),
    .ok        (ok),
    .read_byte (read_byte)
);
